### sv/ens_pkg.sv
// ============================================================================
// ens_pkg : shared types and constants for the epsilon neighbor search
// Sizes of the point store, field widths, register indexes and the structs
// that pass between the store, the distance pipeline and the result queue.
// ============================================================================
package ens_pkg;

    // store geometry
    localparam int MAX_POINTS = 64;
    localparam int MAX_DIMS   = 5;
    localparam int COORD_BITS = 16;

    localparam int IDX_W = $clog2(MAX_POINTS);

    // fixed field and register widths
    localparam int IDX_FIELD_W   = 6;
    localparam int COORD_FIELD_W = 16;
    localparam int NUM_COORDS    = 5;
    localparam int DIM_W         = 3;
    localparam int PC_W          = 7;
    localparam int EPS_W         = 35;

    // stream packing
    localparam int S_FIELDS_W = IDX_FIELD_W + NUM_COORDS * COORD_FIELD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((IDX_FIELD_W + 7) / 8) * 8;

    // distance arithmetic
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + $clog2(MAX_DIMS);
    localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

    // config port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = EPS_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIMENSIONS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EPS_SQUARED = 2'd2;

    localparam logic [DIM_W-1:0] DIMS_RESET = 3'd2;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef coord_t [MAX_DIMS-1:0] row_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        row_t             data;
    } store_wr_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } dist_res_t;

    typedef struct packed {
        logic                   last;
        logic [IDX_FIELD_W-1:0] idx;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t data;
    } fifo_push_t;

    // low COORD_BITS of the field, sign extended if the store is wider
    function automatic coord_t sext_coord(logic signed [COORD_FIELD_W-1:0] raw);
        return COORD_BITS'(raw);
    endfunction

endpackage

### sv/epsilon_neighbour_search_top.sv
// ============================================================================
// epsilon_neighbour_search_top : epsilon neighborhood query over a point store
// Loads points into a 64-row store and answers radius queries by a full scan.
// ============================================================================
// A load word (tuser = 0) writes one point into the store.
// A query word (tuser = 1) names a stored point; the block scans rows
// 0 .. point_count-1 and returns, in ascending order, the index of every row
// whose squared distance to the named row (over the first `dimensions`
// coordinates) is at most eps_squared, with tlast on the final one. A query
// whose index is not below point_count returns nothing.
// When the queue has room, a query holds the input while the block fetches
// the query row, reads one store row per cycle through the single read port,
// empties the distance pipeline and releases the final result. Results go
// through a 16-word queue; when the m_ side stalls and the queue fills, the
// scan pauses. The next input word is taken once the scan has finished, even
// if results still sit in the queue. The user must see that configuration is
// written only while idle; the block itself does not enforce it.
// ============================================================================
module epsilon_neighbour_search_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] point_index, [21:6] coord_0, [37:22] coord_1, [53:38] coord_2,
    // [69:54] coord_3, [85:70] coord_4, [87:86] zero
    input  logic [ens_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] opcode (0 load, 1 query)
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] neighbour_index, [7:6] zero
    output logic [ens_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [ens_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ens_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ens_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QROW,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // config registers
    logic [DIM_W-1:0]   dims_reg;
    logic [PC_W-1:0]    pc_reg;
    logic [EPS_W-1:0]   eps_reg;
    logic [DIM_W-1:0]   dims_used;
    logic [PC_W-1:0]    n_used;

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]   s1_idx_reg, s1_idx_next;
    logic               pending_valid_reg, pending_valid_next;
    logic [IDX_W-1:0]   pending_idx_reg, pending_idx_next;
    row_t               qrow_reg, qrow_next;

    // datapath links
    logic               in_acc;
    logic [IDX_FIELD_W-1:0] in_idx;
    logic               query_ok;
    logic               issue;
    logic               scan_last;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    row_t               rd_data;
    store_wr_t          store_wr;
    dist_res_t          dres;
    logic [2:0]         stage_valid;
    logic [2:0]         inflight;
    logic [FIFO_CNT_W:0] credit_use;
    logic [FIFO_CNT_W-1:0] fifo_count;
    fifo_push_t         fifo_wr;
    result_t            head;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= DIMS_RESET;
            pc_reg   <= '0;
            eps_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DIMENSIONS:  dims_reg <= cfg_wdata[DIM_W-1:0];
                CFG_POINT_COUNT: pc_reg   <= cfg_wdata[PC_W-1:0];
                CFG_EPS_SQUARED: eps_reg  <= cfg_wdata[EPS_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // zero dims acts as one, too many as MAX_DIMS; count clamps to store size
    always_comb begin
        if (dims_reg == '0) begin
            dims_used = DIM_W'(1);
        end else if (int'(dims_reg) > MAX_DIMS) begin
            dims_used = DIM_W'(MAX_DIMS);
        end else begin
            dims_used = dims_reg;
        end
        n_used = (int'(pc_reg) > MAX_POINTS) ? PC_W'(MAX_POINTS) : pc_reg;
    end

    // ---------------- input decode ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_idx   = s_tdata[IDX_FIELD_W-1:0];

    always_comb begin
        store_wr.en   = in_acc && (s_tuser == OP_LOAD)
                        && (int'(in_idx) < MAX_POINTS);
        store_wr.addr = in_idx[IDX_W-1:0];
        for (int d = 0; d < MAX_DIMS; d++) begin
            store_wr.data[d] =
                sext_coord(s_tdata[IDX_FIELD_W + d*COORD_FIELD_W +: COORD_FIELD_W]);
        end
    end

    // query of an index past point_count is dropped here
    assign query_ok = in_acc && (s_tuser == OP_QUERY) && (PC_W'(in_idx) < n_used);

    // ---------------- scan issue with queue credits ----------------
    // every row in flight plus the held result may still land in the queue
    assign inflight   = 3'(s1_valid_reg) + 3'(stage_valid[0])
                      + 3'(stage_valid[1]) + 3'(stage_valid[2]);
    assign credit_use = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(inflight)
                      + (FIFO_CNT_W+1)'(pending_valid_reg);
    assign issue      = (state_reg == ST_SCAN)
                      && (credit_use < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign scan_last  = (PC_W'(scan_idx_reg) == n_used - PC_W'(1));

    assign rd_en   = query_ok || issue;
    assign rd_addr = query_ok ? in_idx[IDX_W-1:0] : scan_idx_reg;

    // ---------------- control / result hold ----------------
    always_comb begin
        state_next         = state_reg;
        scan_idx_next      = scan_idx_reg;
        s1_valid_next      = issue;
        s1_idx_next        = scan_idx_reg;
        pending_valid_next = pending_valid_reg;
        pending_idx_next   = pending_idx_reg;
        qrow_next          = qrow_reg;
        fifo_wr.push       = 1'b0;
        fifo_wr.data.last  = 1'b0;
        fifo_wr.data.idx   = IDX_FIELD_W'(pending_idx_reg);

        // a new hit releases the previous one, which therefore is not last
        if (dres.valid && dres.hit) begin
            fifo_wr.push       = pending_valid_reg;
            pending_valid_next = 1'b1;
            pending_idx_next   = dres.idx;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (query_ok) begin
                    state_next = ST_QROW;
                end
            end
            ST_QROW: begin
                qrow_next     = rd_data;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    if (scan_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // pipeline empty: the held hit is the final one
                if (inflight == '0) begin
                    fifo_wr.push       = pending_valid_reg;
                    fifo_wr.data.last  = 1'b1;
                    pending_valid_next = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            s1_valid_reg      <= 1'b0;
            pending_valid_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            s1_valid_reg      <= s1_valid_next;
            pending_valid_reg <= pending_valid_next;
        end
        scan_idx_reg    <= scan_idx_next;
        s1_idx_reg      <= s1_idx_next;
        pending_idx_reg <= pending_idx_next;
        qrow_reg        <= qrow_next;
    end

    // ---------------- submodules ----------------
    ens_store u_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ens_dist u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s1_valid_reg),
        .in_idx      (s1_idx_reg),
        .row         (rd_data),
        .query_row   (qrow_reg),
        .dims_used   (dims_used),
        .eps_sq      (eps_reg),
        .res         (dres),
        .stage_valid (stage_valid)
    );

    ens_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (fifo_wr),
        .count     (fifo_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = M_TDATA_W'(head.idx);
    assign m_tlast = head.last;

    // ---------------- checks ----------------
    // nothing left in flight once back in idle
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (!s1_valid_reg && stage_valid == '0
                                  && !pending_valid_reg))
        else $error("scan state left behind in idle");

    // credits keep the queue from overrunning
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_wr.push |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overrun");

    // scan reads stay below the clamped point count
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (PC_W'(scan_idx_reg) < n_used))
        else $error("scan read past point count");

    // distance results only appear during a query
    a_res_in_query: assert property (@(posedge aclk) disable iff (!aresetn)
        dres.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance result outside a query");

endmodule

### sv/ens_store.sv
// ============================================================================
// ens_store : point store
// One row per point holding all coordinates. One write port, one read port,
// read data registered.
// ============================================================================
module ens_store (
    input  logic                            aclk,
    input  ens_pkg::store_wr_t              wr,
    input  logic                            rd_en,
    input  logic [ens_pkg::IDX_W-1:0]       rd_addr,
    output ens_pkg::row_t                   rd_data
);
    import ens_pkg::*;

    row_t mem [MAX_POINTS];
    row_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/ens_dist.sv
// ============================================================================
// ens_dist : squared distance pipeline
// abs diff -> square -> sum, then compare against eps. Three register stages.
// ============================================================================
module ens_dist (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  logic [ens_pkg::IDX_W-1:0]       in_idx,
    input  ens_pkg::row_t                   row,
    input  ens_pkg::row_t                   query_row,
    input  logic [ens_pkg::DIM_W-1:0]       dims_used,
    input  logic [ens_pkg::EPS_W-1:0]       eps_sq,
    output ens_pkg::dist_res_t              res,
    output logic [2:0]                      stage_valid
);
    import ens_pkg::*;

    logic                       s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [IDX_W-1:0]           s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [COORD_BITS-1:0]      s2_abs_reg  [MAX_DIMS];
    logic [COORD_BITS-1:0]      s2_abs_next [MAX_DIMS];
    logic [SQ_W-1:0]            s3_sq_reg   [MAX_DIMS];
    logic [SUM_W-1:0]           s4_sum_reg;
    logic [SUM_W-1:0]           sum_next;

    // |a - b|, zeroed for unused dimensions
    always_comb begin
        logic signed [COORD_BITS:0] diff;
        for (int d = 0; d < MAX_DIMS; d++) begin
            diff = $signed({row[d][COORD_BITS-1], row[d]})
                 - $signed({query_row[d][COORD_BITS-1], query_row[d]});
            if (d < int'(dims_used)) begin
                s2_abs_next[d] = diff[COORD_BITS] ? COORD_BITS'(-diff)
                                                  : COORD_BITS'(diff);
            end else begin
                s2_abs_next[d] = '0;
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sum_next = sum_next + SUM_W'(s3_sq_reg[d]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_idx_reg <= in_idx;
        s3_idx_reg <= s2_idx_reg;
        s4_idx_reg <= s3_idx_reg;
        for (int d = 0; d < MAX_DIMS; d++) begin
            s2_abs_reg[d] <= s2_abs_next[d];
            s3_sq_reg[d]  <= SQ_W'(s2_abs_reg[d]) * SQ_W'(s2_abs_reg[d]);
        end
        s4_sum_reg <= sum_next;
    end

    assign res.valid   = s4_valid_reg;
    assign res.idx     = s4_idx_reg;
    assign res.hit     = (CMP_W'(s4_sum_reg) <= CMP_W'(eps_sq));
    assign stage_valid = {s4_valid_reg, s3_valid_reg, s2_valid_reg};

endmodule

### sv/ens_out_fifo.sv
// ============================================================================
// ens_out_fifo : result queue
// Small register queue between the scan and the m_ side; decouples scan
// from output stalls. Push side never overruns (caller holds credits).
// ============================================================================
module ens_out_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ens_pkg::fifo_push_t                wr,
    output logic [ens_pkg::FIFO_CNT_W-1:0]     count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ens_pkg::result_t                   out_data
);
    import ens_pkg::*;

    result_t                ent_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = ent_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr.push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!wr.push && pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            ent_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

### tb/testbench.sv
// ============================================================================
// testbench : self-checking bench for epsilon_neighbour_search_top
// Fills the point store, then sends load and query words over the input
// stream under many search settings. A scoreboard keeps its own copy of the
// store and the registers, works out the neighbor list of every accepted
// query, and checks each result word against it in order. Both stream sides
// idle at random, and once the result side holds off long enough for the
// block to back up into its input.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ens_pkg::*;

    localparam int DRAIN_CYCLES    = 80;   // a full 64-row scan plus pipeline
    localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall, fills the queue

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the store and registers, predicts neighbor lists
    // ------------------------------------------------------------------------
    class neighbourhood_model;
        row_t             point_rows [MAX_POINTS];
        logic [DIM_W-1:0] dims_reg;
        logic [PC_W-1:0]  count_reg;
        logic [EPS_W-1:0] eps_reg;
        result_t          expected_neighbours [$];
        int               errors;

        function new();
            dims_reg  = DIMS_RESET;
            count_reg = '0;
            eps_reg   = '0;
            errors    = 0;
            foreach (point_rows[i]) point_rows[i] = '0;
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                CFG_DIMENSIONS:  dims_reg  = value[DIM_W-1:0];
                CFG_POINT_COUNT: count_reg = value[PC_W-1:0];
                CFG_EPS_SQUARED: eps_reg   = value[EPS_W-1:0];
                default: ;
            endcase
        endfunction

        // 0 behaves as 1, anything above the store width as MAX_DIMS
        function int dims_eff();
            if (dims_reg == 0) return 1;
            if (dims_reg > MAX_DIMS) return MAX_DIMS;
            return int'(dims_reg);
        endfunction

        function int count_eff();
            if (count_reg > MAX_POINTS) return MAX_POINTS;
            return int'(count_reg);
        endfunction

        function longint unsigned sq_dist(int a, int b, int nd);
            longint unsigned sum;
            longint          diff;
            int              d;
            sum = 0;
            for (d = 0; d < nd; d++) begin
                diff = longint'($signed(point_rows[a][d])) - longint'($signed(point_rows[b][d]));
                sum += diff * diff;
            end
            return sum;
        endfunction

        // an accepted input word: loads update the store, queries queue results
        function void note_word(logic op, logic [IDX_FIELD_W-1:0] idx, row_t row);
            int      n;
            int      nd;
            int      i;
            int      hits [$];
            result_t r;
            if (op == OP_LOAD) begin
                if (idx < MAX_POINTS) point_rows[idx] = row;
                return;
            end
            n  = count_eff();
            nd = dims_eff();
            if (idx >= n) return;
            for (i = 0; i < n; i++)
                if (sq_dist(i, idx, nd) <= eps_reg) hits.push_back(i);
            foreach (hits[k]) begin
                r.idx  = IDX_FIELD_W'(hits[k]);
                r.last = (k == hits.size() - 1);
                expected_neighbours.push_back(r);
            end
        endfunction

        task check_neighbour(logic [IDX_FIELD_W-1:0] idx, logic last);
            result_t want;
            if (expected_neighbours.size() == 0) begin
                flag_mismatch($sformatf("unexpected neighbor %0d last=%0b", idx, last));
                return;
            end
            want = expected_neighbours.pop_front();
            if (idx !== want.idx)
                flag_mismatch($sformatf("neighbor index %0d, expected %0d", idx, want.idx));
            if (last !== want.last)
                flag_mismatch($sformatf("last=%0b on neighbor %0d, expected %0b",
                                        last, want.idx, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // idx, coord_0 .. coord_4, pad
    logic                  s_tuser;     // opcode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // neighbour_index, pad
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    neighbourhood_model sb = new();

    bit quiet_phase      = 1'b0;  // no idling on either side while set
    bit hold_off_request = 1'b0;  // asks the result sink for one long stall

    epsilon_neighbour_search_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int send_gap();
        if (quiet_phase || $urandom_range(0, 1) == 0) return 0;
        return idle_length();
    endfunction

    function automatic row_t random_row();
        row_t r;
        foreach (r[d]) r[d] = coord_t'($urandom());
        return r;
    endfunction

    // point scattered around base, so small radii still catch neighbors
    function automatic row_t near_row(row_t base, int spread);
        row_t r;
        int   d;
        for (d = 0; d < MAX_DIMS; d++)
            r[d] = base[d] + coord_t'($urandom_range(0, 2 * spread)) - coord_t'(spread);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks: each starts and ends just after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [IDX_FIELD_W-1:0] idx,
                             input row_t row);
        int gap;
        gap = send_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({row, idx});
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, idx, row);
    endtask

    task automatic load_point(input int idx, input row_t row);
        send_word(OP_LOAD, IDX_FIELD_W'(idx), row);
    endtask

    // coordinates of a query word are don't-care, so they carry noise
    task automatic ask_neighbours(input int idx);
        send_word(OP_QUERY, IDX_FIELD_W'(idx), random_row());
    endtask

    // registers may change only once every neighbor has come out and the
    // last word (possibly a silent load or query) has left the block
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_neighbours.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        sb.write_reg(addr, value);
    endtask

    task automatic set_search(input logic [DIM_W-1:0] dims, input logic [PC_W-1:0] count,
                              input logic [EPS_W-1:0] eps);
        write_register(CFG_DIMENSIONS, CFG_DATA_W'(dims));
        write_register(CFG_POINT_COUNT, CFG_DATA_W'(count));
        write_register(CFG_EPS_SQUARED, CFG_DATA_W'(eps));
    endtask

    // new search settings for a random phase; small counts dominate since
    // a query scans every stored point
    task automatic random_settings();
        logic [DIM_W-1:0] dims;
        logic [PC_W-1:0]  count;
        logic [EPS_W-1:0] eps;
        int               r;
        int               n;
        int               sel;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            dims = DIM_W'($urandom_range(1, MAX_DIMS));
        end else begin
            sel  = $urandom_range(0, 2);
            dims = (sel == 0) ? DIM_W'(0) : DIM_W'(MAX_DIMS + sel);
        end
        r = $urandom_range(0, 99);
        if (r < 65)      count = PC_W'($urandom_range(2, 16));
        else if (r < 85) count = PC_W'($urandom_range(17, 64));
        else begin
            case ($urandom_range(0, 3))
                0:       count = PC_W'(0);
                1:       count = PC_W'(1);
                2:       count = PC_W'(MAX_POINTS);
                default: count = PC_W'($urandom_range(65, 127));
            endcase
        end
        write_register(CFG_DIMENSIONS, CFG_DATA_W'(dims));
        write_register(CFG_POINT_COUNT, CFG_DATA_W'(count));

        // radius taken from a real pair of points cuts the set somewhere inside
        n = sb.count_eff();
        if (n == 0) n = MAX_POINTS;
        r = $urandom_range(0, 99);
        if (r < 55)
            eps = EPS_W'(sb.sq_dist($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                    sb.dims_eff()));
        else if (r < 65) eps = '0;
        else if (r < 75) eps = '1;
        else if (r < 85) eps = EPS_W'({$urandom(), $urandom()});
        else             eps = EPS_W'($urandom_range(0, 1 << 20));
        write_register(CFG_EPS_SQUARED, CFG_DATA_W'(eps));

        quiet_phase = ($urandom_range(0, 3) == 0);
    endtask

    // mostly in-range queries; loads keep reshaping the store
    task automatic random_phase(input int items);
        int   k;
        int   n;
        row_t row;
        for (k = 0; k < items; k++) begin
            n = sb.count_eff();
            if ($urandom_range(0, 99) < 78) begin
                if (n > 0 && $urandom_range(0, 99) < 88) ask_neighbours($urandom_range(0, n - 1));
                else ask_neighbours($urandom_range(0, MAX_POINTS - 1));
            end else begin
                if ($urandom_range(0, 1)) row = random_row();
                else row = near_row(sb.point_rows[$urandom_range(0, MAX_POINTS - 1)],
                                    $urandom_range(1, 2000));
                load_point($urandom_range(0, MAX_POINTS - 1), row);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: checks every word taken, idles at random, and serves the
    // one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int ready_wait;
        ready_wait = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_neighbour(m_tdata[IDX_FIELD_W-1:0], m_tlast);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                ready_wait       = HOLD_OFF_CYCLES;
            end
            if (ready_wait > 0) begin
                m_tready <= 1'b0;
                ready_wait--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 99) < 25) ready_wait = idle_length();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int   i;
        int   p;
        row_t row;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOAD;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_DIMENSIONS;
        cfg_wdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings have point_count = 0: every query is out of range
        ask_neighbours(0);
        ask_neighbours(MAX_POINTS - 1);

        // fill the whole store before any query can read it; the first rows
        // hold the coordinate extremes, the rest are spread or clustered at random
        load_point(0, row_t'({MAX_DIMS{16'h7FFF}}));
        load_point(1, row_t'({MAX_DIMS{16'h8000}}));
        load_point(2, row_t'('0));
        load_point(3, row_t'('1));
        load_point(4, row_t'({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}));
        for (i = 5; i < MAX_POINTS; i++) begin
            if ($urandom_range(0, 1)) row = random_row();
            else row = near_row(sb.point_rows[i - 1], 500);
            load_point(i, row);
        end

        // widest possible distance: corners 0 and 1 are exactly eps apart
        settle();
        set_search(3'd5, 7'd64, 35'd21474181125);
        ask_neighbours(0);
        ask_neighbours(1);
        // one less drops the opposite corner
        settle();
        write_register(CFG_EPS_SQUARED, CFG_DATA_W'(35'd21474181124));
        ask_neighbours(0);
        ask_neighbours(1);
        // zero radius: only identical points
        settle();
        write_register(CFG_EPS_SQUARED, '0);
        ask_neighbours(2);
        ask_neighbours(MAX_POINTS - 1);
        // dimensions 0 behaves as one coordinate
        settle();
        set_search(3'd0, 7'd64, 35'd1);
        ask_neighbours(2);
        ask_neighbours(3);
        // oversized dimensions and point count clamp, full-scale radius
        settle();
        set_search(3'd7, 7'd127, '1);
        ask_neighbours(MAX_POINTS - 1);
        // queries at and past point_count return nothing; index 9 is still in range
        settle();
        set_search(3'd2, 7'd10, 35'd100000000);
        ask_neighbours(20);
        ask_neighbours(9);
        ask_neighbours(10);
        // a single point takes part
        settle();
        set_search(3'd3, 7'd1, '0);
        ask_neighbours(0);
        ask_neighbours(1);

        // back-pressure: every point matches, the sink stalls for a long
        // stretch and the input must stall once the result queue is full
        settle();
        set_search(3'd5, 7'd64, '1);
        quiet_phase      = 1'b1;
        hold_off_request = 1'b1;
        for (i = 0; i < 6; i++) ask_neighbours($urandom_range(0, MAX_POINTS - 1));

        // random phases, each with fresh search settings
        for (p = 0; p < 12; p++) begin
            settle();
            random_settings();
            random_phase(18);
        end

        settle();
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin : watchdog
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
